[sv/accel_moving_average_offset_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the accelerometer moving-average core
// Clocked property checks with reset disable; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ACCEL_MOVING_AVERAGE_OFFSET_CORE_ASSERT_SVH
`define ACCEL_MOVING_AVERAGE_OFFSET_CORE_ASSERT_SVH

`ifndef SYNTH
`define AMAO_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define AMAO_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define AMAO_ASSERT(lbl, clk, rst_n, prop)
`define AMAO_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

[sv/amao_pkg.sv]
// ----------------------------------------------------------------------------
// amao_pkg
// Shared constants, types and the sample scaling function.
// ----------------------------------------------------------------------------
package amao_pkg;

  localparam int WINDOW      = 8;
  localparam int WINDOW_LOG2 = 3;
  localparam int SLOT_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W      = $clog2(WINDOW + 1);

  localparam int BYTE_W      = 8;
  localparam int SAMPLE_W    = 16;
  localparam int TERM_W      = SAMPLE_W - WINDOW_LOG2;
  localparam int SUM_W       = TERM_W + WINDOW_LOG2;
  localparam int OUT_W       = 22;
  localparam int PROD_W      = 22;
  localparam int SCALE       = 10000;
  localparam int SCALE_SHIFT = 6;

  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 4;
  localparam int IDX_W       = ADDR_W - 2;

  typedef enum logic [IDX_W-1:0] {
    REG_OFFSET_X = 2'd0,
    REG_OFFSET_Y = 2'd1,
    REG_OFFSET_Z = 2'd2,
    REG_UNUSED   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } offsets_t;

  function automatic logic signed [TERM_W-1:0] scale_term(input logic [BYTE_W-1:0] b);
    logic signed [PROD_W-1:0]   prod;
    logic signed [SAMPLE_W-1:0] sample;
    prod   = $signed({{(PROD_W-BYTE_W){b[BYTE_W-1]}}, b}) * PROD_W'(SCALE);
    sample = SAMPLE_W'(prod >>> SCALE_SHIFT);
    return TERM_W'(sample >>> WINDOW_LOG2);
  endfunction

endpackage

[sv/amao_cfg.sv]
// ----------------------------------------------------------------------------
// amao_cfg
// APB-style register file holding the three calibration offsets.
// ----------------------------------------------------------------------------
module amao_cfg
  import amao_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output offsets_t          offsets_o
);

  offsets_t offsets_q, offsets_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    offsets_d = offsets_q;
    if (wr_en) begin
      unique case (idx)
        REG_OFFSET_X: offsets_d.x = $signed(pwdata[OUT_W-1:0]);
        REG_OFFSET_Y: offsets_d.y = $signed(pwdata[OUT_W-1:0]);
        REG_OFFSET_Z: offsets_d.z = $signed(pwdata[OUT_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_OFFSET_X: prdata = DATA_W'(offsets_q.x);
      REG_OFFSET_Y: prdata = DATA_W'(offsets_q.y);
      REG_OFFSET_Z: prdata = DATA_W'(offsets_q.z);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offsets_q <= '0;
    end else begin
      offsets_q <= offsets_d;
    end
  end

  assign offsets_o = offsets_q;

endmodule

[sv/amao_axis.sv]
// ----------------------------------------------------------------------------
// amao_axis
// One axis: scale a raw byte, keep a ring of window terms and a running sum.
// ----------------------------------------------------------------------------
module amao_axis
  import amao_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_en_i,
  input  logic [SLOT_W-1:0]       slot_i,
  input  logic [BYTE_W-1:0]       byte_i,
  output logic signed [SUM_W-1:0] sum_o
);

  logic signed [TERM_W-1:0] ring_q [WINDOW];
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic signed [TERM_W-1:0] term;

  assign term  = scale_term(byte_i);
  assign sum_d = sum_q + SUM_W'(term) - SUM_W'(ring_q[slot_i]);
  assign sum_o = sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        ring_q[i] <= '0;
      end
      sum_q <= '0;
    end else if (wr_en_i) begin
      ring_q[slot_i] <= term;
      sum_q          <= sum_d;
    end
  end

endmodule

[sv/accel_moving_average_offset_core.sv]
// ----------------------------------------------------------------------------
// accel_moving_average_offset_core
// Windowed average of three accelerometer axes with calibration offsets.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one request of three raw
// two's-complement sensor bytes. Sensor x feeds the y result, sensor y the x.
// Output channel: out_valid_o / out_stall_i carry accel_x/y/z, each the sum of
// the last WINDOW scaled samples shifted by WINDOW_LOG2, minus its offset
// (x negated first). No result is given for the first WINDOW-1 requests.
// Throughput: one request per cycle, set by the per-axis running-sum update.
// When the receiver stalls, the result register holds and the input register
// still takes one more request; further requests stall until the result is
// taken. Reset clears the rings, sums, fill count, slot and offsets. The user
// writes offsets over the APB-style port at 0x0, 0x4 and 0x8 only while idle;
// the block does not enforce it.
// ----------------------------------------------------------------------------
`include "accel_moving_average_offset_core_assert.svh"

module accel_moving_average_offset_core
  import amao_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [BYTE_W-1:0]       out_x_byte_i,
  input  logic [BYTE_W-1:0]       out_y_byte_i,
  input  logic [BYTE_W-1:0]       out_z_byte_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] accel_x_o,
  output logic signed [OUT_W-1:0] accel_y_o,
  output logic signed [OUT_W-1:0] accel_z_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready
);

  offsets_t                offsets;
  logic                    s1_valid_q;
  logic [BYTE_W-1:0]       x_byte_q, y_byte_q, z_byte_q;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  logic [FILL_W-1:0]       fill_q, fill_d;
  logic                    out_valid_q;
  logic signed [OUT_W-1:0] accel_x_q, accel_y_q, accel_z_q;
  logic                    out_ready, advance, full;
  logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
  logic signed [OUT_W:0]   res_x, res_y, res_z;

  amao_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .offsets_o (offsets)
  );

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;

  amao_axis u_axis_x (
    .clk_i(clk_i), .rst_ni(rst_ni), .wr_en_i(advance), .slot_i(slot_q),
    .byte_i(y_byte_q), .sum_o(sum_x)
  );
  amao_axis u_axis_y (
    .clk_i(clk_i), .rst_ni(rst_ni), .wr_en_i(advance), .slot_i(slot_q),
    .byte_i(x_byte_q), .sum_o(sum_y)
  );
  amao_axis u_axis_z (
    .clk_i(clk_i), .rst_ni(rst_ni), .wr_en_i(advance), .slot_i(slot_q),
    .byte_i(z_byte_q), .sum_o(sum_z)
  );

  assign slot_d = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
  assign full   = (fill_q >= FILL_W'(WINDOW - 1));
  assign fill_d = full ? FILL_W'(WINDOW) : fill_q + 1'b1;

  assign res_x = -((OUT_W+1)'(sum_x)) - (OUT_W+1)'(offsets.x);
  assign res_y =  ((OUT_W+1)'(sum_y)) - (OUT_W+1)'(offsets.y);
  assign res_z =  ((OUT_W+1)'(sum_z)) - (OUT_W+1)'(offsets.z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      x_byte_q <= out_x_byte_i;
      y_byte_q <= out_y_byte_i;
      z_byte_q <= out_z_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= advance && full;
      if (advance) begin
        slot_q <= slot_d;
        fill_q <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && full) begin
      accel_x_q <= $signed(res_x[OUT_W-1:0]);
      accel_y_q <= $signed(res_y[OUT_W-1:0]);
      accel_z_q <= $signed(res_z[OUT_W-1:0]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign accel_x_o   = accel_x_q;
  assign accel_y_o   = accel_y_q;
  assign accel_z_o   = accel_z_q;

  `AMAO_ASSERT_NEVER(a_fill_bound, clk_i, rst_ni, fill_q > FILL_W'(WINDOW))
  `AMAO_ASSERT_NEVER(a_slot_bound, clk_i, rst_ni, slot_q > SLOT_W'(WINDOW - 1))
  `AMAO_ASSERT(a_stall_full, clk_i, rst_ni, in_stall_o |-> s1_valid_q)
  `AMAO_ASSERT(a_result_when_full, clk_i, rst_ni, (advance && full) |=> out_valid_o)
  `AMAO_ASSERT(a_no_early_result, clk_i, rst_ni, (advance && !full) |=> !out_valid_o)

endmodule
